@@ hw/rtl/bpedec_pkg.sv @@
// shared constants for the byte-level bpe text decoder
// used by bpedec_revert and byte_level_bpe_text_decoder; no dependencies
package bpedec_pkg;

    localparam int CODE_W = 21;
    localparam int BYTE_W = 8;

    // utf-8 lead byte classification
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_CODE  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_CODE  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_CODE  = 8'hF0;
    localparam logic [7:0] CONT_MASK   = 8'h3F;

    // reverse table: codes from 256 up name the unprintable bytes in order
    localparam logic [12:0] UNPRINT_PAGE  = 13'd1;
    localparam logic [7:0]  UNPRINT_LAST  = 8'd67;
    localparam logic [7:0]  LOW_CTRL_CNT  = 8'd33;
    localparam logic [7:0]  DEL_BYTE      = 8'd127;
    localparam logic [7:0]  HIGH_CTRL_END = 8'd67;
    localparam logic [7:0]  SOFT_HYPHEN   = 8'd173;

    localparam logic [7:0]  SPACE_BYTE    = 8'd32;

endpackage

@@ hw/rtl/bpedec_revert.sv @@
// byte-level bpe reverse table: maps one decoded code point to a raw byte
// depends on bpedec_pkg
module bpedec_revert
    import bpedec_pkg::*;
(
    input  logic [CODE_W-1:0] code,
    output logic [BYTE_W-1:0] raw_byte
);

    logic [12:0] code_page;
    logic [7:0]  code_low;

    assign code_page = code[CODE_W-1:8];
    assign code_low  = code[7:0];

    // printable codes already equal their low byte, only page one differs
    always_comb begin
        raw_byte = code_low;
        if (code_page == UNPRINT_PAGE && code_low <= UNPRINT_LAST) begin
            if (code_low < LOW_CTRL_CNT) begin
                raw_byte = code_low;
            end else if (code_low < HIGH_CTRL_END) begin
                raw_byte = code_low + (DEL_BYTE - LOW_CTRL_CNT);
            end else begin
                raw_byte = SOFT_HYPHEN;
            end
        end
    end

endmodule

@@ hw/rtl/byte_level_bpe_text_decoder.sv @@
// byte-level bpe text decoder: utf-8 decode, reverse byte table, leading space drop
// depends on bpedec_pkg and bpedec_revert
// a result appears on m_ in the cycle after the transfer that completes it, from a register
// throughput: one input byte per cycle while s_tready is high, zero or one result byte per input byte
// s_tready follows the single output register: high when it is empty or being drained
// reset (aresetn low, synchronous): no sequence open, leading-space drop armed, m_tvalid low
module byte_level_bpe_text_decoder
    import bpedec_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] tok_byte
    input  logic       s_tlast,   // tok_last
    input  logic       s_tuser,   // seq_start
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [7:0] out_byte
);

    logic [1:0]        bytes_pending_reg, bytes_pending_next;
    logic [CODE_W-1:0] code_accum_reg, code_accum_next;
    logic              first_out_pending_reg, first_out_pending_next;
    logic              m_tvalid_reg;
    logic [7:0]        m_tdata_reg;

    logic              s_accept;
    logic [1:0]        pend_in;
    logic [CODE_W-1:0] acc_in;
    logic [CODE_W-1:0] acc_shift;
    logic              first_in;
    logic              done;
    logic [CODE_W-1:0] code;
    logic [7:0]        raw_byte;
    logic              emit;

    assign s_tready = ~m_tvalid_reg | m_tready;
    assign s_accept = s_tvalid & s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign acc_shift = {acc_in[CODE_W-7:0], s_tdata[5:0] & CONT_MASK[5:0]};

    always_comb begin
        // a new string drops any open sequence and rearms the space drop
        pend_in  = s_tuser ? 2'd0 : bytes_pending_reg;
        acc_in   = s_tuser ? '0 : code_accum_reg;
        first_in = s_tuser | first_out_pending_reg;

        bytes_pending_next = pend_in;
        code_accum_next    = acc_in;
        done               = 1'b0;
        code               = '0;

        if (pend_in == 2'd0) begin
            if (s_tdata < ASCII_LIMIT) begin
                code = {{(CODE_W-8){1'b0}}, s_tdata};
                done = 1'b1;
            end else if ((s_tdata & LEAD2_MASK) == LEAD2_CODE) begin
                code_accum_next    = {{(CODE_W-5){1'b0}}, s_tdata[4:0]};
                bytes_pending_next = 2'd1;
            end else if ((s_tdata & LEAD3_MASK) == LEAD3_CODE) begin
                code_accum_next    = {{(CODE_W-4){1'b0}}, s_tdata[3:0]};
                bytes_pending_next = 2'd2;
            end else if ((s_tdata & LEAD4_MASK) == LEAD4_CODE) begin
                code_accum_next    = {{(CODE_W-3){1'b0}}, s_tdata[2:0]};
                bytes_pending_next = 2'd3;
            end
            // anything else is a stray byte and is skipped
        end else begin
            // continuation bits are taken without checking the 10 prefix
            bytes_pending_next = pend_in - 2'd1;
            code_accum_next    = acc_shift;
            if (pend_in == 2'd1) begin
                code            = acc_shift;
                code_accum_next = '0;
                done            = 1'b1;
            end
        end

        // a sequence left open at the token end is discarded
        if (s_tlast && bytes_pending_next != 2'd0) begin
            bytes_pending_next = 2'd0;
            code_accum_next    = '0;
        end

        first_out_pending_next = done ? 1'b0 : first_in;
        emit = done & ~(first_in & (raw_byte == SPACE_BYTE));
    end

    bpedec_revert u_revert (
        .code     (code),
        .raw_byte (raw_byte)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_pending_reg     <= 2'd0;
            code_accum_reg        <= '0;
            first_out_pending_reg <= 1'b1;
            m_tvalid_reg          <= 1'b0;
        end else begin
            if (s_accept) begin
                bytes_pending_reg     <= bytes_pending_next;
                code_accum_reg        <= code_accum_next;
                first_out_pending_reg <= first_out_pending_next;
            end
            if (s_tready) begin
                m_tvalid_reg <= s_accept & emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && emit) begin
            m_tdata_reg <= raw_byte;
        end
    end

    // no sequence survives the end of a token
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |=> (bytes_pending_reg == 2'd0))
        else $error("sequence still open after token end");

    // a leading space on a fresh string is consumed without a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser && s_tdata == SPACE_BYTE) |=>
            (!first_out_pending_reg && !m_tvalid_reg))
        else $error("leading space not dropped");

    // a stray byte with no open sequence leaves the state alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !s_tuser && bytes_pending_reg == 2'd0 &&
         s_tdata[7:6] == 2'b10) |=>
            (bytes_pending_reg == 2'd0 &&
             first_out_pending_reg == $past(first_out_pending_reg)))
        else $error("stray byte changed decoder state");

    // reset leaves no sequence open and the space drop armed
    assert property (@(posedge aclk)
        !aresetn |=> (first_out_pending_reg && bytes_pending_reg == 2'd0 && !m_tvalid_reg))
        else $error("bad state after reset");

endmodule

@@ verif/bpe_decode_checker.sv @@
// transfer checker for the byte-level bpe text decoder: predicts each recovered byte
// from the input transfers and compares it with the output transfers
// standalone, no dependency on the rtl package
`timescale 1ns / 100ps

module bpe_decode_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] tok_byte
    input  logic       s_tlast,   // tok_last
    input  logic       s_tuser,   // seq_start
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] out_byte
    output int         fail_count,
    output int         outstanding
);

    localparam logic [7:0] SPACE_CHAR = 8'd32;
    localparam logic [7:0] SHY_CHAR   = 8'd173;

    // decoder state as the block should hold it
    logic [1:0]  cont_left;
    logic [20:0] code_acc;
    logic        first_pending;

    logic [7:0]  expected_bytes[$];

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    // byte-level reverse table
    function automatic logic [7:0] byte_for_code(input logic [20:0] cp);
        int unsigned idx;
        if ((cp >= 33 && cp <= 126) || (cp >= 161 && cp <= 172) ||
            (cp >= 174 && cp <= 255)) begin
            return cp[7:0];
        end
        if (cp >= 256 && cp <= 323) begin
            idx = cp - 256;
            if (idx < 33) begin
                return idx[7:0];
            end
            if (idx < 67) begin
                return 8'(127 + idx - 33);
            end
            return SHY_CHAR;
        end
        return cp[7:0];
    endfunction

    task automatic decode_byte(input logic [7:0] c, input logic last, input logic start,
                               output logic produced, output logic [7:0] raw);
        logic [20:0] cp;
        logic        done;
        cp       = '0;
        done     = 1'b0;
        produced = 1'b0;
        raw      = '0;
        if (start) begin
            first_pending = 1'b1;
            cont_left     = '0;
            code_acc      = '0;
        end
        if (cont_left == 2'd0) begin
            if (c < 8'h80) begin
                cp   = {13'd0, c};
                done = 1'b1;
            end else if ((c & 8'hE0) == 8'hC0) begin
                code_acc  = {16'd0, c[4:0]};
                cont_left = 2'd1;
            end else if ((c & 8'hF0) == 8'hE0) begin
                code_acc  = {17'd0, c[3:0]};
                cont_left = 2'd2;
            end else if ((c & 8'hF8) == 8'hF0) begin
                code_acc  = {18'd0, c[2:0]};
                cont_left = 2'd3;
            end
            // anything else is a stray byte and is skipped
        end else begin
            // continuation bits are taken without checking the tag
            code_acc  = {code_acc[14:0], c[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
                cp       = code_acc;
                code_acc = '0;
                done     = 1'b1;
            end
        end
        if (last && cont_left != 2'd0) begin
            cont_left = '0;
            code_acc  = '0;
        end
        if (done) begin
            raw = byte_for_code(cp);
            if (first_pending) begin
                first_pending = 1'b0;
                produced      = (raw != SPACE_CHAR);
            end else begin
                produced = 1'b1;
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    always @(posedge aclk) begin : watch
        logic       produced;
        logic [7:0] raw;
        logic [7:0] want;
        if (!aresetn) begin
            cont_left     = '0;
            code_acc      = '0;
            first_pending = 1'b1;
            expected_bytes.delete();
        end else begin
            // output first: a result never leaves in the cycle its input arrives
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected output byte 0x%02h", m_tdata));
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want) begin
                        report_mismatch($sformatf("out_byte 0x%02h, predicted 0x%02h",
                                                  m_tdata, want));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata, s_tlast, s_tuser, produced, raw);
                if (produced) begin
                    expected_bytes = {expected_bytes, raw};
                end
            end
        end
        outstanding <= expected_bytes.size();
    end

endmodule

@@ verif/tb.sv @@
// testbench top for byte_level_bpe_text_decoder: clock, reset, token byte stimulus,
// output back-pressure and the verdict; checking is done in bpe_decode_checker
`timescale 1ns / 100ps

module tb;

    localparam int RANDOM_ITEMS = 700;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_AT      = 420;
    localparam int HOLD_CYCLES  = 64;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;
    logic       s_tlast  = 1'b0;
    logic       s_tuser  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;

    logic       calm     = 1'b0;
    logic       hold_off = 1'b0;
    int         sent_count = 0;
    int         quiet_cycles = 0;
    int         fail_count;
    int         outstanding;
    logic [7:0] tok_bytes[$];

    always #5 aclk = ~aclk;

    byte_level_bpe_text_decoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bpe_decode_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // receiver: random stalls, none while calm, a long hold-off once
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !hold_off && (calm || $urandom_range(99) >= 18);
        end
    end

    initial begin
        wait (sent_count >= HOLD_AT);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [7:0] b, input logic last, input logic start);
        while (!calm && $urandom_range(99) < 18) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        s_tuser  <= start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count++;
    endtask

    task automatic append_byte(input logic [7:0] b);
        tok_bytes = {tok_bytes, b};
    endtask

    // utf-8 encoding of one code point, up to 21 bits
    task automatic queue_code(input logic [20:0] cp);
        if (cp < 21'h80) begin
            append_byte(cp[7:0]);
        end else if (cp < 21'h800) begin
            append_byte({3'b110, cp[10:6]});
            append_byte({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            append_byte({4'b1110, cp[15:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
        end else begin
            append_byte({5'b11110, cp[20:18]});
            append_byte({2'b10, cp[17:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
        end
    endtask

    // mostly characters a byte-level vocabulary really holds, some odd codes
    function automatic logic [20:0] pick_code();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30) return 21'($urandom_range(126, 33));
        if (r < 40) return 21'($urandom_range(255, 161));
        if (r < 60) return 21'($urandom_range(323, 256));
        if (r < 75) return 21'd288;   // marker for a space
        if (r < 80) return 21'd32;
        if (r < 90) return 21'($urandom_range(21'h7FF, 0));
        return 21'($urandom_range(21'h1FFFFF, 0));
    endfunction

    task automatic send_token(input logic new_string, input logic truncate);
        int n;
        int len_before;
        int cut;
        n = $urandom_range(4, 1);
        tok_bytes.delete();
        repeat (n) queue_code(pick_code());
        if (truncate) begin
            // the token ends inside a multi-byte character
            len_before = tok_bytes.size();
            queue_code(21'($urandom_range(21'h1FFFFF, 21'h80)));
            cut = $urandom_range(tok_bytes.size() - len_before - 1, 1);
            repeat (cut) void'(tok_bytes.pop_back());
        end
        foreach (tok_bytes[i]) begin
            send_item(tok_bytes[i], i == tok_bytes.size() - 1, new_string && i == 0);
        end
    endtask

    initial begin
        int unsigned pick;
        int          goal;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: leading space drop, table edges, sequence lengths, stray bytes
        send_item(8'h20, 1'b0, 1'b1);
        send_item(8'h20, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h7F, 1'b0, 1'b0);
        send_item(8'h21, 1'b1, 1'b0);
        send_item(8'hC4, 1'b0, 1'b0);
        send_item(8'h80, 1'b0, 1'b0);
        send_item(8'hC5, 1'b0, 1'b0);
        send_item(8'h83, 1'b0, 1'b0);
        send_item(8'hC2, 1'b0, 1'b0);
        send_item(8'hAD, 1'b1, 1'b0);
        send_item(8'hEF, 1'b0, 1'b0);
        send_item(8'hBF, 1'b0, 1'b0);
        send_item(8'hBF, 1'b0, 1'b0);
        send_item(8'hF7, 1'b0, 1'b0);
        send_item(8'hBF, 1'b0, 1'b0);
        send_item(8'hBF, 1'b0, 1'b0);
        send_item(8'hBF, 1'b1, 1'b0);
        send_item(8'h80, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'hF8, 1'b1, 1'b0);
        // cut short at token end, then plain ascii
        send_item(8'hE2, 1'b0, 1'b0);
        send_item(8'h82, 1'b1, 1'b0);
        send_item(8'h41, 1'b1, 1'b0);
        // new string inside an open sequence, its first byte a space marker
        send_item(8'hC4, 1'b0, 1'b0);
        send_item(8'hC4, 1'b0, 1'b1);
        send_item(8'hA0, 1'b0, 1'b0);
        // ascii taken as a continuation
        send_item(8'hC3, 1'b0, 1'b0);
        send_item(8'h41, 1'b1, 1'b0);
        // stray byte leaves the leading space drop armed
        send_item(8'hBF, 1'b0, 1'b1);
        send_item(8'h20, 1'b1, 1'b0);

        goal = sent_count + RANDOM_ITEMS;
        while (sent_count < goal) begin
            calm <= (sent_count >= goal - 500) && (sent_count < goal - 370);
            pick = $urandom_range(99);
            if (pick < 75) begin
                send_token($urandom_range(99) < 20, 1'b0);
            end else if (pick < 87) begin
                send_token($urandom_range(99) < 20, 1'b1);
            end else begin
                repeat ($urandom_range(4, 1)) begin
                    send_item(8'($urandom_range(255)), 1'($urandom_range(1)),
                              $urandom_range(9) == 0);
                end
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
